FILE: hdl/plm_pkg.sv
// Shared types and constants for the pooled linked list manager.
// Used by plm_ctrl, plm_dp and the top level pooled_linked_list_manager.
`timescale 1ns / 1ps

package plm_pkg;

  // Default sizing
  localparam int unsigned PLM_POOL_SLOTS = 16;
  localparam int unsigned PLM_KEY_WIDTH  = 32;

  // Fixed port field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;

  // Operation codes carried on func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } plm_func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } plm_status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;   // latch key, restart free-slot scan
    logic scan_step;   // advance free-slot scan
    logic alloc;       // take scanned slot, link at tail
    logic set_full;    // no free slot
    logic clear_list;  // drop every node
    logic nop_ok;      // unused selector
    logic walk_start;  // read head node
    logic walk_step;   // move to next node
    logic unlink;      // remove current node
    logic not_found;   // empty list or no match
    logic head_fix;    // load new head key from read data
    logic out_load;    // move result into output register
  } plm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic head_null;   // list empty
    logic slot_free;   // scanned slot is free
    logic scan_last;   // scan at last slot
    logic match;       // current node key equals item key
    logic at_tail;     // current node is the tail
    logic new_head;    // unlink of head leaves a successor
    logic out_free;    // output register can take a result
  } plm_stat_t;

endpackage

FILE: hdl/plm_ctrl.sv
// Controller state machine of the pooled linked list manager.
// Depends on plm_pkg for operation codes and the command/status structs.
`timescale 1ns / 1ps

module plm_ctrl
  import plm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  plm_stat_t         stat_i,
  output plm_cmd_t          cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_WALK = 5'b00100,
    ST_HFIX = 5'b01000,
    ST_DONE = 5'b10000
  } plm_state_e;

  plm_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          case (func_i)
            FUNC_APPEND: begin
              state_d = ST_SCAN;
            end
            FUNC_REMOVE: begin
              if (stat_i.head_null) begin
                cmd_o.not_found = 1'b1;
                state_d         = ST_DONE;
              end else begin
                cmd_o.walk_start = 1'b1;
                state_d          = ST_WALK;
              end
            end
            FUNC_CLEAR: begin
              cmd_o.clear_list = 1'b1;
              state_d          = ST_DONE;
            end
            default: begin
              cmd_o.nop_ok = 1'b1;
              state_d      = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.slot_free) begin
          cmd_o.alloc = 1'b1;
          state_d     = ST_DONE;
        end else if (stat_i.scan_last) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (stat_i.match) begin
          cmd_o.unlink = 1'b1;
          state_d      = stat_i.new_head ? ST_HFIX : ST_DONE;
        end else if (stat_i.at_tail) begin
          cmd_o.not_found = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_HFIX: begin
        cmd_o.head_fix = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/plm_dp.sv
// Datapath of the pooled linked list manager: node key and link memories,
// used bits, head/tail pointers, result and output registers. Uses plm_pkg.
`timescale 1ns / 1ps

module plm_dp
  import plm_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = PLM_POOL_SLOTS,
  parameter int unsigned KEY_WIDTH  = PLM_KEY_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_W-1:0]    key_i,
  input  plm_cmd_t            cmd_i,
  output plm_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic                is_empty_o,
  output logic [KEY_W-1:0]    head_value_o,
  output logic                head_valid_o
);

  // Slot index width, pointer width with room for the null marker
  localparam int unsigned IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned PW = $clog2(POOL_SLOTS + 1);
  // Stored key bits: the port carries 32, the parameter may narrow it
  localparam int unsigned KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(POOL_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(POOL_SLOTS - 1);

  // Node storage
  logic [KW-1:0] val_mem  [POOL_SLOTS];
  logic [IW-1:0] link_mem [POOL_SLOTS];

  logic [POOL_SLOTS-1:0] used_q;
  logic [PW-1:0]         head_q, tail_q, prev_q;
  logic [IW-1:0]         curr_q, scan_q;
  logic [KW-1:0]         key_q, head_val_q;
  logic [KW-1:0]         rd_val_q;
  logic [IW-1:0]         rd_link_q;
  logic [IW-1:0]         rd_addr;
  logic                  link_we;
  logic [IW-1:0]         link_waddr, link_wdata;

  // Result and output registers
  logic [STATUS_W-1:0] res_status_q;
  logic [IW-1:0]       res_slot_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_hvalid_q;
  logic [KW-1:0]       out_hval_q;
  logic [IW+SLOT_W-1:0] slot_ext;

  logic head_null, tail_null, prev_null, at_tail, match;

  assign head_null = (head_q == NULL_PTR);
  assign tail_null = (tail_q == NULL_PTR);
  assign prev_null = (prev_q == NULL_PTR);
  assign at_tail   = (PW'(curr_q) == tail_q);
  assign match     = (rd_val_q == key_q);

  assign stat_o.head_null = head_null;
  assign stat_o.slot_free = ~used_q[scan_q];
  assign stat_o.scan_last = (scan_q == LAST_SLOT);
  assign stat_o.match     = match;
  assign stat_o.at_tail   = at_tail;
  assign stat_o.new_head  = prev_null & ~at_tail;
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  // Read address: head on walk start, otherwise the link just read
  assign rd_addr = cmd_i.walk_start ? head_q[IW-1:0] : rd_link_q;

  // Single link write port: tail on append, predecessor on unlink
  always_comb begin
    link_we    = 1'b0;
    link_waddr = tail_q[IW-1:0];
    link_wdata = scan_q;
    if (cmd_i.alloc && !tail_null) begin
      link_we = 1'b1;
    end else if (cmd_i.unlink && !prev_null) begin
      link_we    = 1'b1;
      link_waddr = prev_q[IW-1:0];
      link_wdata = rd_link_q;
    end
  end

  // Memories with registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      val_mem[scan_q] <= key_q;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_val_q  <= val_mem[rd_addr];
    rd_link_q <= link_mem[rd_addr];
  end

  // List control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      head_q      <= NULL_PTR;
      tail_q      <= NULL_PTR;
      prev_q      <= NULL_PTR;
      curr_q      <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        scan_q <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.alloc) begin
        used_q[scan_q] <= 1'b1;
        tail_q         <= PW'(scan_q);
        if (tail_null) begin
          head_q <= PW'(scan_q);
        end
      end
      if (cmd_i.clear_list) begin
        used_q <= '0;
        head_q <= NULL_PTR;
        tail_q <= NULL_PTR;
      end
      if (cmd_i.walk_start) begin
        curr_q <= head_q[IW-1:0];
        prev_q <= NULL_PTR;
      end
      if (cmd_i.walk_step) begin
        prev_q <= PW'(curr_q);
        curr_q <= rd_link_q;
      end
      if (cmd_i.unlink) begin
        used_q[curr_q] <= 1'b0;
        if (prev_null) begin
          head_q <= at_tail ? NULL_PTR : PW'(rd_link_q);
        end
        if (at_tail) begin
          tail_q <= prev_q;
        end
      end
      // Output handshake
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Key, head key and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      key_q <= key_i[KW-1:0];
    end
    if (cmd_i.alloc && tail_null) begin
      head_val_q <= key_q;
    end
    if (cmd_i.head_fix) begin
      head_val_q <= rd_val_q;
    end
    if (cmd_i.alloc) begin
      res_status_q <= STAT_OK;
      res_slot_q   <= scan_q;
    end
    if (cmd_i.unlink) begin
      res_status_q <= STAT_OK;
      res_slot_q   <= curr_q;
    end
    if (cmd_i.clear_list || cmd_i.nop_ok) begin
      res_status_q <= STAT_OK;
      res_slot_q   <= '0;
    end
    if (cmd_i.set_full) begin
      res_status_q <= STAT_FULL;
      res_slot_q   <= '0;
    end
    if (cmd_i.not_found) begin
      res_status_q <= STAT_MISS;
      res_slot_q   <= '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= slot_ext[SLOT_W-1:0];
      out_hvalid_q <= ~head_null;
      out_hval_q   <= head_null ? '0 : head_val_q;
    end
  end

  // Slot number reported on its low bits only
  assign slot_ext = (IW + SLOT_W)'(res_slot_q);

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;
  assign is_empty_o   = ~out_hvalid_q;
  assign head_valid_o = out_hvalid_q;
  assign head_value_o = KEY_W'(out_hval_q);

endmodule

FILE: hdl/pooled_linked_list_manager.sv
// Pooled linked list manager: one singly linked list of keys in a fixed
// pool of node slots. The list is kept in node key and link memories with
// a used bit per slot. A controller (plm_ctrl) sequences each item; the
// datapath (plm_dp) holds the list and the output register.
//
// Input channel: in_valid_i/in_ready_o with func_i and key_i. Output
// channel: out_valid_o/out_ready_i with status, slot, empty flag, head.
// One result per item; items are handled one at a time.
// After an item is accepted: a clear or unused selector goes straight to the
// done state; an append scans the used bits from slot 0 for the lowest free
// slot, or reports full after the last slot; a remove walks from the head
// until a match, with a head fix step when the head is removed and nodes
// remain, or reports a miss at the tail, or at once when the list is empty.
// The remove walk visits one node per cycle through the link memory read
// port; the append scan checks one used bit per cycle.
// The next item is accepted in the idle state that follows the load of its
// predecessor's result into the output register. If the receiver stalls,
// the finished result waits there and the following item is held back in
// its done state until it drains.
// Reset empties the list, frees every slot and drops any pending result.
`timescale 1ns / 1ps

module pooled_linked_list_manager
  import plm_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = PLM_POOL_SLOTS,
  parameter int unsigned KEY_WIDTH  = PLM_KEY_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic                is_empty_o,
  output logic [KEY_W-1:0]    head_value_o,
  output logic                head_valid_o
);

  plm_cmd_t  cmd;
  plm_stat_t stat;

  // Sequencer
  plm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // List storage and result path
  plm_dp #(
    .POOL_SLOTS (POOL_SLOTS),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .is_empty_o   (is_empty_o),
    .head_value_o (head_value_o),
    .head_valid_o (head_valid_o)
  );

endmodule
